// File: rtl/hsf_pkg.sv
`default_nettype none
package hsf_pkg;

  // Input command codes, carried in in_tuser.
  typedef enum logic [1:0] {
    CMD_TRANS = 2'd0,
    CMD_INIT  = 2'd1,
    CMD_LIK   = 2'd2,
    CMD_START = 2'd3
  } cmd_t;

  // Control strobes broadcast from the sequencer to every cell.
  typedef struct packed {
    logic start;
    logic mac_mul;
    logic mac_acc;
    logic rotate;
    logic raw_mul;
    logic raw_reg;
    logic div_load;
    logic div_step;
    logic commit;
    logic first;
    logic zero;
  } cell_ctl_t;

  // ln(2) in Q0.32.
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  localparam logic [31:0] LOG_MIN = 32'h8000_0000;
  localparam logic [31:0] LOG_MAX = 32'h7FFF_FFFF;

endpackage
`default_nettype wire

// File: rtl/hsf_cell.sv
`default_nettype none
module hsf_cell #(
  parameter int MAX_STATES     = 16,
  parameter int PROB_FRAC_BITS = 16,
  parameter int IDX            = 0
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  hsf_pkg::cell_ctl_t                    ctl,
  input  wire                                   active,
  input  wire                                   wr_tr,
  input  wire                                   wr_init,
  input  wire                                   wr_lik,
  input  wire  [$clog2(MAX_STATES)-1:0]         wr_row,
  input  wire  [PROB_FRAC_BITS:0]               wr_val,
  input  wire  [PROB_FRAC_BITS:0]               nb_fwd,
  input  wire  [$clog2(MAX_STATES)-1:0]         nb_ptr,
  input  wire  [PROB_FRAC_BITS+2*$clog2(MAX_STATES):0] scale_i,
  output logic [PROB_FRAC_BITS:0]               fwd_o,
  output logic [$clog2(MAX_STATES)-1:0]         ptr_o,
  output logic [PROB_FRAC_BITS+$clog2(MAX_STATES):0] raw_o
);
  import hsf_pkg::*;

  localparam int F   = PROB_FRAC_BITS;
  localparam int PW  = F + 1;
  localparam int IW  = $clog2(MAX_STATES);
  localparam int RW  = F + IW + 1;
  localparam int SW  = F + 2 * IW + 1;
  localparam int ACW = 2 * F + IW + 1;
  localparam int PRW = RW + PW;
  localparam int DW  = SW + PW;
  localparam logic [ACW:0] HALF_A = (ACW + 1)'(1) << (F - 1);
  localparam logic [PRW:0] HALF_P = (PRW + 1)'(1) << (F - 1);

  logic [PW-1:0]  tcol [MAX_STATES];
  logic [PW-1:0]  init_r;
  logic [PW-1:0]  lik_r;
  logic [PW-1:0]  fwd_r;
  logic [IW-1:0]  ptr_r;
  logic [PRW-1:0] prod_r;
  logic [ACW-1:0] acc_r;
  logic [RW-1:0]  raw_r;
  logic [SW-1:0]  rem_r;
  logic [PW-1:0]  dlo_r;
  logic [PW-1:0]  q_r;

  logic [ACW:0]   s_full;
  logic [RW-1:0]  mul_a;
  logic [PW-1:0]  mul_b;
  logic [PRW:0]   p_rnd;
  logic [DW-1:0]  dsum;
  logic [SW:0]    trial;
  logic [SW:0]    diff;
  logic           ge;

  always_comb begin
    s_full = {1'b0, acc_r} + HALF_A;
    if (ctl.mac_mul) begin
      mul_a = RW'(fwd_r);
      mul_b = tcol[ptr_r];
    end else begin
      mul_a = ctl.first ? RW'(init_r) : s_full[F +: RW];
      mul_b = lik_r;
    end
    p_rnd = {1'b0, prod_r} + HALF_P;
    dsum  = DW'({raw_r, {F{1'b0}}}) + DW'(scale_i >> 1);
    trial = {rem_r, dlo_r[PW-1]};
    diff  = trial - {1'b0, scale_i};
    ge    = (trial >= {1'b0, scale_i});
  end

  always_ff @(posedge clk) begin
    if (wr_tr) tcol[wr_row] <= wr_val;
    if (wr_init) init_r <= wr_val;
    if (wr_lik) lik_r <= wr_val;
    if (ctl.mac_mul || ctl.raw_mul) prod_r <= PRW'(mul_a) * PRW'(mul_b);
    if (ctl.start) begin
      acc_r <= '0;
    end else if (ctl.mac_acc) begin
      acc_r <= acc_r + prod_r[ACW-1:0];
    end
    if (ctl.raw_reg) raw_r <= p_rnd[F +: RW];
    // The division keeps only the remainder below the scale; the low
    // dividend bits are shifted in one per cycle.
    if (ctl.div_load) begin
      rem_r <= dsum[DW-1:PW];
      dlo_r <= dsum[PW-1:0];
    end else if (ctl.div_step) begin
      rem_r <= ge ? diff[SW-1:0] : trial[SW-1:0];
      dlo_r <= {dlo_r[PW-2:0], 1'b0};
      q_r   <= {q_r[PW-2:0], ge};
    end
  end

  // The forward value and its row pointer circulate round the active cells.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= '0;
      ptr_r <= IW'(IDX);
    end else if (ctl.start) begin
      ptr_r <= IW'(IDX);
    end else if (ctl.rotate && active) begin
      fwd_r <= nb_fwd;
      ptr_r <= nb_ptr;
    end else if (ctl.commit && active) begin
      fwd_r <= ctl.zero ? '0 : q_r;
    end
  end

  assign fwd_o = fwd_r;
  assign ptr_o = ptr_r;
  assign raw_o = raw_r;

endmodule
`default_nettype wire

// File: rtl/hsf_ln.sv
`default_nettype none
module hsf_ln #(
  parameter int SW             = 25,
  parameter int PROB_FRAC_BITS = 16
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           start,
  input  wire  [SW-1:0] scale,
  output logic          done,
  output logic [31:0]   ln_val
);
  import hsf_pkg::*;

  typedef enum logic [4:0] {
    L_IDLE = 5'b00001,
    L_NORM = 5'b00010,
    L_SQ   = 5'b00100,
    L_MUL  = 5'b01000,
    L_RND  = 5'b10000
  } ln_state_t;

  ln_state_t      state_r;
  logic [SW-1:0]  x_r;
  logic [5:0]     p_r;
  logic [30:0]    m_r;
  logic [15:0]    frac_r;
  logic [3:0]     k_r;
  logic [55:0]    prod_r;
  logic           neg_r;
  logic           done_r;
  logic [31:0]    ln_r;

  logic [SW+30:0] norm;
  logic [61:0]    sq;
  logic [31:0]    t;
  logic [7:0]     pd;
  logic [23:0]    l;
  logic [23:0]    mag;
  logic [55:0]    rs;

  always_comb begin
    norm = {x_r, 31'b0};
    sq   = 62'(m_r) * 62'(m_r);
    t    = sq[61:30];
    pd   = {2'b00, p_r} - 8'(PROB_FRAC_BITS);
    l    = {pd, frac_r};
    mag  = l[23] ? (~l + 24'd1) : l;
    rs   = prod_r + (56'd1 << 31);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        L_IDLE: begin
          if (start) begin
            x_r     <= scale;
            p_r     <= 6'(SW - 1);
            state_r <= L_NORM;
          end
        end
        L_NORM: begin
          if (x_r[SW-1]) begin
            m_r     <= norm[SW+30 -: 31];
            k_r     <= '0;
            frac_r  <= '0;
            state_r <= L_SQ;
          end else begin
            x_r <= {x_r[SW-2:0], 1'b0};
            p_r <= p_r - 6'd1;
          end
        end
        L_SQ: begin
          // One fraction bit of log2 per squaring, most significant first.
          m_r    <= t[31] ? t[31:1] : t[30:0];
          frac_r <= {frac_r[14:0], t[31]};
          k_r    <= k_r + 4'd1;
          if (k_r == 4'd15) state_r <= L_MUL;
        end
        L_MUL: begin
          neg_r   <= l[23];
          prod_r  <= 56'(mag) * 56'(LN2_Q32);
          state_r <= L_RND;
        end
        L_RND: begin
          ln_r    <= neg_r ? (~32'(rs[55:32]) + 32'd1) : 32'(rs[55:32]);
          done_r  <= 1'b1;
          state_r <= L_IDLE;
        end
        default: state_r <= L_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign ln_val = ln_r;

endmodule
`default_nettype wire

// File: rtl/hmm_scaled_forward.sv
`default_nettype none
// Channel  Direction  Handshake                 Payload
// in_      slave      in_tvalid / in_tready     tdata, tuser = command
// out_     master     out_tvalid / out_tready   tdata, tuser = zero scale, tlast
// cfg_     slave      cfg_valid / cfg_ready     cfg_data = n_states
//
// Writes, starts and likelihoods that do not close a time step are taken while idle.
// The likelihood of state N-1 starts a time step: multiply-accumulate as the forward
// vector circulates round the cell row, summing the scale, bit-serial division in every
// cell, the hand-over states MACW, RAWM, RAWR, DIVL and CMT and, unless the scale is
// zero, the shared log unit, which normalises the scale by its leading one; then N
// result transfers, each held while out_tready is low.
// Reset is synchronous; the output register lets the last result wait while the
// next input transfer is taken.
module hmm_scaled_forward #(
  parameter int MAX_STATES     = 16,
  parameter int PROB_FRAC_BITS = 16
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_tvalid,
  output logic                                  in_tready,
  // from_state [4:0], to_state [9:5], prob_value above, zero fill
  input  wire  [((PROB_FRAC_BITS+11+7)/8)*8-1:0] in_tdata,
  // cmd [1:0]
  input  wire  [1:0]                            in_tuser,
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  // state_index, forward_value, scale_factor, log_likelihood, zero fill
  output logic [((2*PROB_FRAC_BITS+44+7)/8)*8-1:0] out_tdata,
  // zero_scale [0]
  output logic                                  out_tuser,
  output logic                                  out_tlast,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire  [5:0]                            cfg_data
);
  import hsf_pkg::*;

  localparam int F      = PROB_FRAC_BITS;
  localparam int PW     = F + 1;
  localparam int IW     = $clog2(MAX_STATES);
  localparam int RW     = F + IW + 1;
  localparam int SW     = F + 2 * IW + 1;
  localparam int OSW    = F + 6;
  localparam int OUT_DW = ((5 + PW + OSW + 32 + 7) / 8) * 8;
  localparam logic [PW-1:0]  ONE_Q   = PW'(1) << F;
  localparam logic [SW+5:0]  SAT_EXT = ((SW + 6)'(1) << (F + 5)) - (SW + 6)'(1);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_MAC  = 11'b00000000010,
    S_MACW = 11'b00000000100,
    S_RAWM = 11'b00000001000,
    S_RAWR = 11'b00000010000,
    S_SUM  = 11'b00000100000,
    S_DIVL = 11'b00001000000,
    S_DIV  = 11'b00010000000,
    S_CMT  = 11'b00100000000,
    S_LOG  = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [5:0]      n_r;
  logic [5:0]      cnt_r;
  logic            mac_d_r;
  logic            first_r;
  logic            zero_r;
  logic [SW-1:0]   scale_r;
  logic [31:0]     log_r;
  logic            out_valid_r;
  logic [OUT_DW-1:0] out_data_r;
  logic            out_last_r;
  logic            out_zero_r;

  cell_ctl_t       ctl;
  logic [5:0]      n_eff;
  logic [5:0]      nm1;
  logic            in_acc;
  cmd_t            cmd;
  logic [4:0]      from_s;
  logic [4:0]      to_s;
  logic [PW-1:0]   val_raw;
  logic [PW-1:0]   val;
  logic            from_ok;
  logic            to_ok;
  logic            step_go;
  logic            out_load;
  logic            ln_done;
  logic [31:0]     ln_val;
  logic [32:0]     log_sum;
  logic [SW+5:0]   scale_ext;
  logic [OSW-1:0]  scale_sat;

  logic [PW-1:0]   fwd_all [MAX_STATES];
  logic [IW-1:0]   ptr_all [MAX_STATES];
  logic [RW-1:0]   raw_all [MAX_STATES];

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cmd       = cmd_t'(in_tuser);
  assign from_s    = in_tdata[4:0];
  assign to_s      = in_tdata[9:5];
  assign val_raw   = in_tdata[10 +: PW];
  assign val       = (val_raw > ONE_Q) ? ONE_Q : val_raw;
  assign from_ok   = ({1'b0, from_s} < 6'(MAX_STATES));
  assign to_ok     = ({1'b0, to_s} < 6'(MAX_STATES));

  always_comb begin
    if (n_r == 6'd0) begin
      n_eff = 6'd1;
    end else if (n_r > 6'(MAX_STATES)) begin
      n_eff = 6'(MAX_STATES);
    end else begin
      n_eff = n_r;
    end
  end
  assign nm1     = n_eff - 6'd1;
  assign step_go = in_acc && (cmd == CMD_LIK) && from_ok && ({1'b0, from_s} == nm1);
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    ctl.start    = step_go;
    ctl.mac_mul  = (state_r == S_MAC);
    ctl.rotate   = (state_r == S_MAC);
    ctl.mac_acc  = mac_d_r;
    ctl.raw_mul  = (state_r == S_RAWM);
    ctl.raw_reg  = (state_r == S_RAWR);
    ctl.div_load = (state_r == S_DIVL);
    ctl.div_step = (state_r == S_DIV);
    ctl.commit   = (state_r == S_CMT);
    ctl.first    = first_r;
    ctl.zero     = zero_r;
  end

  genvar g;
  generate
    for (g = 0; g < MAX_STATES; g++) begin : g_cell
      logic [PW-1:0] nb_fwd;
      logic [IW-1:0] nb_ptr;
      logic          is_last;
      assign is_last = (6'(g) == nm1);
      if (g == MAX_STATES - 1) begin : g_end
        assign nb_fwd = fwd_all[0];
        assign nb_ptr = ptr_all[0];
      end else begin : g_mid
        assign nb_fwd = is_last ? fwd_all[0] : fwd_all[g+1];
        assign nb_ptr = is_last ? ptr_all[0] : ptr_all[g+1];
      end
      hsf_cell #(
        .MAX_STATES    (MAX_STATES),
        .PROB_FRAC_BITS(PROB_FRAC_BITS),
        .IDX           (g)
      ) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .active (6'(g) < n_eff),
        .wr_tr  (in_acc && (cmd == CMD_TRANS) && from_ok && to_ok
                 && (to_s[IW-1:0] == IW'(g))),
        .wr_init(in_acc && (cmd == CMD_INIT) && from_ok && (from_s[IW-1:0] == IW'(g))),
        .wr_lik (in_acc && (cmd == CMD_LIK) && from_ok && (from_s[IW-1:0] == IW'(g))),
        .wr_row (from_s[IW-1:0]),
        .wr_val (val),
        .nb_fwd (nb_fwd),
        .nb_ptr (nb_ptr),
        .scale_i(scale_r),
        .fwd_o  (fwd_all[g]),
        .ptr_o  (ptr_all[g]),
        .raw_o  (raw_all[g])
      );
    end
  endgenerate

  hsf_ln #(
    .SW            (SW),
    .PROB_FRAC_BITS(PROB_FRAC_BITS)
  ) u_ln (
    .clk   (clk),
    .rst_n (rst_n),
    .start ((state_r == S_CMT) && !zero_r),
    .scale (scale_r),
    .done  (ln_done),
    .ln_val(ln_val)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (step_go) state_nxt = S_MAC;
      S_MAC:  if (cnt_r == nm1) state_nxt = S_MACW;
      S_MACW: state_nxt = S_RAWM;
      S_RAWM: state_nxt = S_RAWR;
      S_RAWR: state_nxt = S_SUM;
      S_SUM:  if (cnt_r == nm1) state_nxt = S_DIVL;
      S_DIVL: state_nxt = S_DIV;
      S_DIV:  if (cnt_r == 6'(PW - 1)) state_nxt = S_CMT;
      S_CMT:  state_nxt = zero_r ? S_OUT : S_LOG;
      S_LOG:  if (ln_done) state_nxt = S_OUT;
      S_OUT:  if (out_load && (cnt_r == nm1)) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    log_sum   = {log_r[31], log_r} + {ln_val[31], ln_val};
    scale_ext = {6'b0, scale_r};
    scale_sat = (scale_ext > SAT_EXT) ? SAT_EXT[OSW-1:0] : scale_ext[OSW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= 6'd16;
      cnt_r       <= '0;
      mac_d_r     <= 1'b0;
      first_r     <= 1'b1;
      zero_r      <= 1'b0;
      log_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mac_d_r <= (state_r == S_MAC);
      if (cfg_valid) n_r <= cfg_data;
      if (state_nxt != state_r) begin
        cnt_r <= '0;
      end else if ((state_r == S_MAC) || (state_r == S_SUM) || (state_r == S_DIV)
                   || out_load) begin
        cnt_r <= cnt_r + 6'd1;
      end
      if (in_acc && (cmd == CMD_START)) begin
        first_r <= 1'b1;
        log_r   <= '0;
      end
      if (state_r == S_DIVL) zero_r <= (scale_r == '0);
      if (state_r == S_CMT) begin
        first_r <= 1'b0;
        if (zero_r) log_r <= LOG_MIN;
      end
      // Once the log has hit its minimum it stays there until a start or a reset.
      if ((state_r == S_LOG) && ln_done && (log_r != LOG_MIN)) begin
        if (log_sum[32] != log_sum[31]) begin
          log_r <= log_sum[32] ? LOG_MIN : LOG_MAX;
        end else begin
          log_r <= log_sum[31:0];
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RAWR) begin
      scale_r <= '0;
    end else if (state_r == S_SUM) begin
      scale_r <= scale_r + SW'(raw_all[cnt_r[IW-1:0]]);
    end
    if (out_load) begin
      out_data_r <= OUT_DW'({log_r, scale_sat, fwd_all[cnt_r[IW-1:0]], cnt_r[4:0]});
      out_last_r <= (cnt_r == nm1);
      out_zero_r <= zero_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_zero_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire
